### hdl/dd_pkg.sv
// ----------------------------------------------------------------------------
// dd_pkg
// Shared widths, constants, month table and stage-enable type for the
// Gregorian day-count difference pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DIFF_W  = 23;

  // Day ordinal of any 14-bit year stays below 2^23.
  localparam int unsigned ORD_W   = 23;
  // Month start + leap day + day of month stays below 2^9.
  localparam int unsigned MD_W    = 9;
  // Quarter year (year >> 2) and its quotient by 25.
  localparam int unsigned QY_W    = YEAR_W - 2;
  localparam int unsigned C25_W   = 8;

  // t / 25 == (t * 5243) >> 17, exact for t < 43690.
  localparam logic [12:0] RECIP_25    = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned PROD_W      = QY_W + 13;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } dd_stage_en_t;

  // Days of a common year before the first of the month (month is 1..12).
  function automatic logic [MD_W-1:0] month_start(input logic [MONTH_W-1:0] month);
    logic [MD_W-1:0] res;
    unique case (month)
      4'd1:    res = 9'd0;
      4'd2:    res = 9'd31;
      4'd3:    res = 9'd59;
      4'd4:    res = 9'd90;
      4'd5:    res = 9'd120;
      4'd6:    res = 9'd151;
      4'd7:    res = 9'd181;
      4'd8:    res = 9'd212;
      4'd9:    res = 9'd243;
      4'd10:   res = 9'd273;
      4'd11:   res = 9'd304;
      4'd12:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/dd_ord_pipe.sv
// ----------------------------------------------------------------------------
// dd_ord_pipe
// Three-stage day-ordinal unit for one date: clamp and reciprocal divides,
// then whole-year days and in-year days, then their sum.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_ord_pipe
  import dd_pkg::*;
#(
  parameter int unsigned YEAR_MAX = 9999
) (
  input  wire                      clk_i,
  input  dd_stage_en_t             en_i,
  input  wire  [YEAR_W-1:0]        year_i,
  input  wire  [MONTH_W-1:0]       month_i,
  input  wire  [DAY_W-1:0]         day_i,
  output logic [ORD_W-1:0]         ord_o
);

  localparam logic [16:0] YMAX = 17'(YEAR_MAX);

  // Stage 1
  logic [YEAR_W-1:0]  year_cl;
  logic [YEAR_W-1:0]  p_d;
  logic [MONTH_W-1:0] month_cl;
  logic [PROD_W-1:0]  prod_p, prod_y;
  logic [YEAR_W-1:0]  p_q;
  logic [C25_W-1:0]   cp_q, cy_q;
  logic [QY_W-1:0]    yq_q;
  logic [3:0]         ylo_q;
  logic [MONTH_W-1:0] month1_q;
  logic [DAY_W-1:0]   day1_q;

  always_comb begin
    if (year_i == '0) begin
      year_cl = YEAR_W'(1);
    end else if ({3'b000, year_i} > YMAX) begin
      year_cl = YMAX[YEAR_W-1:0];
    end else begin
      year_cl = year_i;
    end
    if (month_i == '0) begin
      month_cl = MONTH_JAN;
    end else if (month_i > MONTH_DEC) begin
      month_cl = MONTH_DEC;
    end else begin
      month_cl = month_i;
    end
    p_d    = year_cl - YEAR_W'(1);
    prod_p = PROD_W'(p_d[YEAR_W-1:2]) * PROD_W'(RECIP_25);
    prod_y = PROD_W'(year_cl[YEAR_W-1:2]) * PROD_W'(RECIP_25);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      p_q      <= p_d;
      cp_q     <= prod_p[RECIP_SHIFT +: C25_W];
      cy_q     <= prod_y[RECIP_SHIFT +: C25_W];
      yq_q     <= year_cl[YEAR_W-1:2];
      ylo_q    <= year_cl[3:0];
      month1_q <= month_cl;
      day1_q   <= day_i;
    end
  end

  // Stage 2
  logic              div25;
  logic              leap;
  logic [ORD_W-1:0]  ys_d;
  logic [MD_W-1:0]   md_d;
  logic [ORD_W-1:0]  ys_q;
  logic [MD_W-1:0]   md_q;

  always_comb begin
    // p/4 - p/100 + p/400, with p/100 = (p/4)/25 and p/400 = (p/100)/4
    ys_d = ORD_W'(p_q) * ORD_W'(DAYS_PER_YEAR)
         + ORD_W'(p_q[YEAR_W-1:2])
         - ORD_W'(cp_q)
         + ORD_W'(cp_q[C25_W-1:2]);
    // year is a multiple of 100 when it is a multiple of 4 and year/4 of 25
    div25 = (yq_q == QY_W'(QY_W'(cy_q) * QY_W'(25)));
    leap  = (ylo_q[1:0] == 2'b00) && (!div25 || (ylo_q[3:2] == 2'b00));
    md_d  = month_start(month1_q)
          + MD_W'((month1_q > MONTH_FEB) && leap)
          + MD_W'(day1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      ys_q <= ys_d;
      md_q <= md_d;
    end
  end

  // Stage 3
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      ord_o <= ys_q + ORD_W'(md_q);
    end
  end

endmodule

`default_nettype wire

### hdl/dd_diff_out.sv
// ----------------------------------------------------------------------------
// dd_diff_out
// Output stage: ordinal difference, saturated to the result width.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_diff_out
  import dd_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      en_i,
  input  wire  [ORD_W-1:0]         ord_a_i,
  input  wire  [ORD_W-1:0]         ord_b_i,
  output logic signed [DIFF_W-1:0] diff_o
);

  logic signed [ORD_W:0]    raw;
  logic signed [DIFF_W-1:0] diff_d;

  always_comb begin
    raw = $signed({1'b0, ord_a_i}) - $signed({1'b0, ord_b_i});
    // top two bits disagree: out of range, clip toward the sign
    if (raw[ORD_W] != raw[ORD_W-1]) begin
      diff_d = raw[ORD_W] ? {1'b1, {(DIFF_W-1){1'b0}}} : {1'b0, {(DIFF_W-1){1'b1}}};
    end else begin
      diff_d = raw[DIFF_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_o <= diff_d;
    end
  end

endmodule

`default_nettype wire

### hdl/date_difference_days_top.sv
// An accepted beat goes through the stage 1, 2 and 3 registers and the output
// register. Throughput: one beat per cycle while the output is not held; each
// of the four stages is a register with its own valid bit, so bubbles close up
// and a held output only stalls the stages behind it once they are full.
// Reset: rst_ni clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// date_difference_days_top
// Signed day count from date b to date a on the proleptic Gregorian calendar.
// ----------------------------------------------------------------------------
`default_nettype none

module date_difference_days_top
  import dd_pkg::*;
#(
  parameter int unsigned YEAR_MAX = 9999
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      valid_i,
  output logic                     stall_o,
  input  wire  [YEAR_W-1:0]        year_a_i,
  input  wire  [MONTH_W-1:0]       month_a_i,
  input  wire  [DAY_W-1:0]         day_a_i,
  input  wire  [YEAR_W-1:0]        year_b_i,
  input  wire  [MONTH_W-1:0]       month_b_i,
  input  wire  [DAY_W-1:0]         day_b_i,
  output logic                     valid_o,
  input  wire                      stall_i,
  output logic signed [DIFF_W-1:0] day_difference_o
);

  logic         v1_q, v2_q, v3_q, vo_q;
  logic         en_out;
  dd_stage_en_t en;
  logic [ORD_W-1:0] ord_a, ord_b;

  // A stage advances when it is empty or the one after it advances.
  always_comb begin
    en_out = !vo_q || !stall_i;
    en.s3  = !v3_q || en_out;
    en.s2  = !v2_q || en.s3;
    en.s1  = !v1_q || en.s2;
  end

  assign stall_o = !en.s1;
  assign valid_o = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en.s1) begin
        v1_q <= valid_i;
      end
      if (en.s2) begin
        v2_q <= v1_q;
      end
      if (en.s3) begin
        v3_q <= v2_q;
      end
      if (en_out) begin
        vo_q <= v3_q;
      end
    end
  end

  dd_ord_pipe #(
    .YEAR_MAX(YEAR_MAX)
  ) u_ord_a (
    .clk_i  (clk_i),
    .en_i   (en),
    .year_i (year_a_i),
    .month_i(month_a_i),
    .day_i  (day_a_i),
    .ord_o  (ord_a)
  );

  dd_ord_pipe #(
    .YEAR_MAX(YEAR_MAX)
  ) u_ord_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .year_i (year_b_i),
    .month_i(month_b_i),
    .day_i  (day_b_i),
    .ord_o  (ord_b)
  );

  dd_diff_out u_diff (
    .clk_i  (clk_i),
    .en_i   (en_out),
    .ord_a_i(ord_a),
    .ord_b_i(ord_b),
    .diff_o (day_difference_o)
  );

endmodule

`default_nettype wire

### hdl/dd_checker.sv
// ----------------------------------------------------------------------------
// dd_checker
// Port-level checks on the day-difference pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_checker
  import dd_pkg::*;
(
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      valid_i,
  input wire                      stall_o,
  input wire                      valid_o,
  input wire                      stall_i,
  input wire signed [DIFF_W-1:0]  day_difference_o
);

  // Hold a stalled result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(day_difference_o))
    else $error("stalled result beat changed");

  // Backpressure only when the output is full and held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled with a free output");

  // An accepted beat reaches the output while stall_i stays low behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) ##1 !stall_i ##1 !stall_i ##1 !stall_i |=> valid_o)
    else $error("result beat missing after pipeline latency");

  // A result only rises on valid_o from an output that was not held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> $past(!stall_i || !valid_o))
    else $error("result appeared while output was held");

endmodule

bind date_difference_days_top dd_checker u_dd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_i         (valid_i),
  .stall_o         (stall_o),
  .valid_o         (valid_o),
  .stall_i         (stall_i),
  .day_difference_o(day_difference_o)
);

`default_nettype wire
